/* src/assert_macros.svh */
// Assertion helpers shared by the RTL. Empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every rising clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expr must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

/* src/bmf_pkg.sv */
package bmf_pkg;

    // pixel counters
    localparam int MAX_PIXELS = 4194304;
    localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PIXELS);

    // mask pixel codes
    localparam logic [7:0] PIX_FG = 8'd0;
    localparam logic [7:0] PIX_BG = 8'd255;

    // score and total formats
    localparam int Q_W    = 17;                 // quotient / image_f1 width
    localparam int DEN_W  = CNT_W + 2;          // 2tp + fp + fn
    localparam int NUM_W  = CNT_W + Q_W;        // 2tp * 2^16 + den/2
    localparam int STEP_W = $clog2(Q_W);
    localparam int SUM_W  = 19;

    localparam int  MAX_IMAGES   = 4;
    localparam longint SUM_RAW   = longint'(MAX_IMAGES) * 65536;
    localparam longint SUM_CAP   = (1 << SUM_W) - 1;
    localparam logic [SUM_W-1:0] SUM_MAX =
        SUM_W'((SUM_RAW > SUM_CAP) ? SUM_CAP : SUM_RAW);
    localparam logic [SUM_W-1:0] INVALID_TOTAL = SUM_W'(655);

    // image job queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // pixel classification
    typedef enum logic [2:0] {
        PX_NONE,
        PX_TP,
        PX_FP,
        PX_FN,
        PX_BAD
    } px_class_t;

    // one finished image handed from front to back
    typedef struct packed {
        logic [CNT_W-1:0] tp;
        logic [CNT_W-1:0] fp;
        logic [CNT_W-1:0] fn;
        logic             invalid;
        logic             last_grp;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // back end sequencer
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PREP,
        BK_SETUP,
        BK_DIV,
        BK_DONE
    } bk_state_t;

endpackage

/* src/binary_mask_f1_score_unit.sv */
// Binary mask F1 scoring unit.
// Throughput: one pixel word per cycle; the front stalls only when four finished
// images wait in the job queue. The divider works on one image at a time.
// The last pixel of an image leads to its score word through queue, setup, 17 divider
// steps and total update; the word is handed on once the output is free.
// Reset (aresetn, synchronous, active low) clears all counts, the total and the queue.
module binary_mask_f1_score_unit import bmf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] pred_pixel, [15:8] target_pixel
    input  logic        s_tlast,   // last_in_image
    input  logic        s_tuser,   // [0] last_in_group
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [16:0] image_f1, [35:17] group_total, zero fill
    output logic        m_tlast,   // group_done
    output logic        m_tuser    // [0] group_invalid
);

    q_stat_t          q_stat;
    logic             q_push, q_pop;
    job_t             push_job, head_job;
    logic [Q_W-1:0]   image_f1;
    logic [SUM_W-1:0] group_total;

    bmf_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .px_valid      (s_tvalid),
        .px_ready      (s_tready),
        .pred_pixel    (s_tdata[7:0]),
        .target_pixel  (s_tdata[15:8]),
        .last_in_image (s_tlast),
        .last_in_group (s_tuser),
        .q_stat        (q_stat),
        .q_push        (q_push),
        .q_job         (push_job)
    );

    bmf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    bmf_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_stat        (q_stat),
        .head_job      (head_job),
        .q_pop         (q_pop),
        .res_valid     (m_tvalid),
        .res_ready     (m_tready),
        .image_f1      (image_f1),
        .group_total   (group_total),
        .group_invalid (m_tuser),
        .group_done    (m_tlast)
    );

    assign m_tdata = {4'b0, group_total, image_f1};

endmodule

/* src/bmf_front.sv */
// Pixel front end: classifies each pixel pair, keeps the saturating counts and
// the group invalid flag, and hands each finished image to the job queue.
module bmf_front import bmf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       px_valid,
    output logic       px_ready,
    input  logic [7:0] pred_pixel,
    input  logic [7:0] target_pixel,
    input  logic       last_in_image,
    input  logic       last_in_group,
    input  q_stat_t    q_stat,
    output logic       q_push,
    output job_t       q_job
);

    logic [CNT_W-1:0] tp_reg, fp_reg, fn_reg;
    logic [CNT_W-1:0] tp_next, fp_next, fn_next;
    logic             inv_reg, inv_next;
    logic [CNT_W-1:0] tp_inc, fp_inc, fn_inc;
    logic             inv_now;
    logic             take;
    px_class_t        px_class;

    assign px_ready = !q_stat.full;
    assign take     = px_valid && px_ready;

    // pixel decoder
    always_comb begin
        if (pred_pixel != PIX_FG && pred_pixel != PIX_BG) begin
            px_class = PX_BAD;
        end else if (pred_pixel == PIX_FG && target_pixel == PIX_FG) begin
            px_class = PX_TP;
        end else if (pred_pixel == PIX_FG && target_pixel == PIX_BG) begin
            px_class = PX_FP;
        end else if (pred_pixel == PIX_BG && target_pixel == PIX_FG) begin
            px_class = PX_FN;
        end else begin
            px_class = PX_NONE;
        end
    end

    // counts including the current pixel
    always_comb begin
        tp_inc  = tp_reg;
        fp_inc  = fp_reg;
        fn_inc  = fn_reg;
        inv_now = inv_reg;
        unique case (px_class)
            PX_TP:   tp_inc  = (tp_reg < CNT_MAX) ? tp_reg + 1'b1 : CNT_MAX;
            PX_FP:   fp_inc  = (fp_reg < CNT_MAX) ? fp_reg + 1'b1 : CNT_MAX;
            PX_FN:   fn_inc  = (fn_reg < CNT_MAX) ? fn_reg + 1'b1 : CNT_MAX;
            PX_BAD:  inv_now = 1'b1;
            default: ;
        endcase
    end

    // counters clear at image end, flag at group end
    always_comb begin
        tp_next  = tp_reg;
        fp_next  = fp_reg;
        fn_next  = fn_reg;
        inv_next = inv_reg;
        if (take) begin
            tp_next  = last_in_image ? '0 : tp_inc;
            fp_next  = last_in_image ? '0 : fp_inc;
            fn_next  = last_in_image ? '0 : fn_inc;
            inv_next = (last_in_image && last_in_group) ? 1'b0 : inv_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tp_reg  <= '0;
            fp_reg  <= '0;
            fn_reg  <= '0;
            inv_reg <= 1'b0;
        end else begin
            tp_reg  <= tp_next;
            fp_reg  <= fp_next;
            fn_reg  <= fn_next;
            inv_reg <= inv_next;
        end
    end

    assign q_push         = take && last_in_image;
    assign q_job.tp       = tp_inc;
    assign q_job.fp       = fp_inc;
    assign q_job.fn       = fn_inc;
    assign q_job.invalid  = inv_now;
    assign q_job.last_grp = last_in_group;

endmodule

/* src/bmf_queue.sv */
`include "assert_macros.svh"
// Small job queue between pixel front end and score back end.
module bmf_queue import bmf_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    head_job,
    output q_stat_t stat
);

    job_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign head_job   = slot_reg[rd_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop  ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // job storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= push_job;
        end
    end

    `ASSERT_NEVER(a_no_overflow, aclk, aresetn, push && stat.full, "queue push while full")
    `ASSERT_NEVER(a_no_underflow, aclk, aresetn, pop && stat.empty, "queue pop while empty")

endmodule

/* src/bmf_back.sv */
`include "assert_macros.svh"
// Score back end: computes F1 of one image with a radix-2 restoring divider,
// updates the saturating group total and holds the result word.
module bmf_back import bmf_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  q_stat_t             q_stat,
    input  job_t                head_job,
    output logic                q_pop,
    output logic                res_valid,
    input  logic                res_ready,
    output logic [Q_W-1:0]      image_f1,
    output logic [SUM_W-1:0]    group_total,
    output logic                group_invalid,
    output logic                group_done
);

    bk_state_t          state_reg, state_next;
    job_t               job_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic [Q_W-1:0]     quo_reg, quo_next;
    logic [STEP_W-1:0]  step_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic               out_valid_reg;
    logic [Q_W-1:0]     f1_reg;
    logic [SUM_W-1:0]   total_reg;
    logic               inv_reg;
    logic               done_reg;

    logic               out_free;
    logic               ld_den, ld_num, div_en, commit;
    logic [NUM_W-1:0]   num;
    logic [DEN_W:0]     trial, diff;
    logic               ge;
    logic [Q_W-1:0]     f1_val;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_sat;

    assign out_free = !out_valid_reg || res_ready;

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:  if (!q_stat.empty) state_next = BK_PREP;
            BK_PREP:  state_next = BK_SETUP;
            BK_SETUP: state_next = BK_DIV;
            BK_DIV:   if (step_reg == STEP_W'(Q_W - 1)) state_next = BK_DONE;
            BK_DONE:  if (out_free) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        q_pop  = 1'b0;
        ld_den = 1'b0;
        ld_num = 1'b0;
        div_en = 1'b0;
        commit = 1'b0;
        unique case (state_reg)
            BK_IDLE:  q_pop  = !q_stat.empty;
            BK_PREP:  ld_den = 1'b1;
            BK_SETUP: ld_num = 1'b1;
            BK_DIV:   div_en = 1'b1;
            BK_DONE:  commit = out_free;
            default:  ;
        endcase
    end

    // numerator with round-half-up bias
    assign num = {job_reg.tp, Q_W'(0)} + NUM_W'(den_reg >> 1);

    // one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[Q_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (ld_num) begin
            rem_next = DEN_W'(num[NUM_W-1:Q_W]);
            quo_next = num[Q_W-1:0];
        end else if (div_en) begin
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[Q_W-2:0], ge};
        end
    end

    // score and saturating total
    assign f1_val   = job_reg.invalid ? '0 : quo_reg;
    assign sum_wide = {1'b0, sum_reg} + (SUM_W+1)'(f1_val);
    assign sum_sat  = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];

    // datapath registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg.tp       <= (head_job.tp == '0) ? CNT_W'(1) : head_job.tp;
            job_reg.fp       <= (head_job.fp == '0) ? CNT_W'(1) : head_job.fp;
            job_reg.fn       <= (head_job.fn == '0) ? CNT_W'(1) : head_job.fn;
            job_reg.invalid  <= head_job.invalid;
            job_reg.last_grp <= head_job.last_grp;
        end
        if (ld_den) begin
            den_reg <= DEN_W'({job_reg.tp, 1'b0}) + DEN_W'(job_reg.fp)
                       + DEN_W'(job_reg.fn);
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (commit) begin
            f1_reg    <= f1_val;
            total_reg <= job_reg.invalid ? INVALID_TOTAL : sum_sat;
            inv_reg   <= job_reg.invalid;
            done_reg  <= job_reg.last_grp;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            step_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= div_en ? step_reg + 1'b1 : '0;
            if (commit) begin
                sum_reg <= job_reg.last_grp ? '0 : sum_sat;
            end
            if (commit) begin
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid     = out_valid_reg;
    assign image_f1      = f1_reg;
    assign group_total   = total_reg;
    assign group_invalid = inv_reg;
    assign group_done    = done_reg;

    `ASSERT_AT(a_rem_below_den, aclk, aresetn,
        (state_reg != BK_DIV) || (rem_reg < den_reg), "divider remainder not below divisor")
    `ASSERT_AT(a_sum_capped, aclk, aresetn, sum_reg <= SUM_MAX, "group total above cap")
    `ASSERT_AT(a_invalid_zero, aclk, aresetn,
        !(out_valid_reg && inv_reg) || (f1_reg == '0 && total_reg == INVALID_TOTAL),
        "invalid group result not forced")

endmodule

/* bench/binary_mask_f1_score_unit_tb.sv */
module binary_mask_f1_score_unit_tb;
    import bmf_pkg::*;

    localparam int     ONE_Q16     = 65536;
    localparam int     RAND_WORDS  = 1400;
    localparam int     HOLD_CYCLES = 300;
    // longest correct quiet spell: receiver hold + divider latency + sender gaps
    localparam int     STALL_LIMIT = 2000;
    localparam int     TAIL_CYCLES = 40;

    // one score word as seen on the master side
    typedef struct packed {
        logic [16:0] f1;
        logic [18:0] total;
        logic        invalid;
        logic        done;
    } score_t;

    // one directed stimulus row, with a hand-written score where it is obvious
    typedef struct packed {
        logic [7:0] pred;
        logic [7:0] tgt;
        logic       last_img;
        logic       last_grp;
        logic       typed;
        score_t     score;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tlast;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    binary_mask_f1_score_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // scoreboard state
    score_t      score_q[$];
    int          errors;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_req;
    bit          hold_done;

    // shadow of the block's counters and group state
    logic [22:0] tp_cnt;
    logic [22:0] fp_cnt;
    logic [22:0] fn_cnt;
    logic [18:0] sum_acc;
    logic        bad_seen;

    // coverage tallies for the summary
    int          n_images;
    int          n_groups;
    int          n_bad_groups;
    int          n_saturated;

    function automatic logic [22:0] count_up(input logic [22:0] c);
        return (c < 23'(MAX_PIXELS)) ? c + 23'd1 : 23'(MAX_PIXELS);
    endfunction

    // update shadow state with one pixel word; returns 1 when a score word is due
    function automatic bit score_pixel(input logic [7:0] pred, input logic [7:0] tgt,
                                       input logic last_img, input logic last_grp,
                                       output score_t res);
        longint t;
        longint f;
        longint n;
        longint d;
        longint q;
        res = '0;
        if (pred != PIX_FG && pred != PIX_BG)
            bad_seen = 1'b1;
        else if (pred == PIX_FG && tgt == PIX_FG)
            tp_cnt = count_up(tp_cnt);
        else if (pred == PIX_FG && tgt == PIX_BG)
            fp_cnt = count_up(fp_cnt);
        else if (pred == PIX_BG && tgt == PIX_FG)
            fn_cnt = count_up(fn_cnt);

        if (!last_img)
            return 0;

        // zero counts are taken as one, then round half up
        t = (tp_cnt == 0) ? 1 : longint'(tp_cnt);
        f = (fp_cnt == 0) ? 1 : longint'(fp_cnt);
        n = (fn_cnt == 0) ? 1 : longint'(fn_cnt);
        d = 2 * t + f + n;
        q = bad_seen ? 0 : (2 * t * ONE_Q16 + d / 2) / d;

        if (longint'(sum_acc) + q > longint'(SUM_MAX)) begin
            sum_acc = SUM_MAX;
            n_saturated++;
        end else begin
            sum_acc = sum_acc + 19'(q);
        end

        res.f1      = 17'(q);
        res.total   = bad_seen ? INVALID_TOTAL : sum_acc;
        res.invalid = bad_seen;
        res.done    = last_grp;

        n_images++;
        tp_cnt = '0;
        fp_cnt = '0;
        fn_cnt = '0;
        if (last_grp) begin
            n_groups++;
            if (bad_seen)
                n_bad_groups++;
            sum_acc  = '0;
            bad_seen = 1'b0;
        end
        return 1;
    endfunction

    // offer one pixel word, wait for it to be taken, then predict
    task automatic send_word(input logic [7:0] pred, input logic [7:0] tgt,
                             input logic last_img, input logic last_grp,
                             input bit typed, input score_t typed_score);
        score_t res;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tgt, pred};
        s_tlast  <= last_img;
        s_tuser  <= last_grp;
        do @(posedge aclk); while (!s_tready);
        if (score_pixel(pred, tgt, last_img, last_grp, res))
            score_q.push_back(typed ? typed_score : res);
    endtask

    // one random image; tp_pct biases toward matching foreground
    task automatic send_image(input int n_px, input int tp_pct, input bit bad_grp,
                              input bit grp_end);
        logic [7:0] pred;
        logic [7:0] tgt;
        logic       last_img;
        logic       last_grp;
        px_class_t  cls;
        for (int i = 0; i < n_px; i++) begin
            if ($urandom_range(99) < tp_pct)
                cls = PX_TP;
            else
                case ($urandom_range(2))
                    0: cls = PX_FP;
                    1: cls = PX_FN;
                    default: cls = PX_NONE;
                endcase
            if (bad_grp && $urandom_range(99) < 5)
                cls = PX_BAD;
            case (cls)
                PX_TP: begin
                    pred = PIX_FG;
                    tgt  = PIX_FG;
                end
                PX_FP: begin
                    pred = PIX_FG;
                    tgt  = PIX_BG;
                end
                PX_FN: begin
                    pred = PIX_BG;
                    tgt  = PIX_FG;
                end
                PX_BAD: begin
                    pred = 8'($urandom_range(254, 1));
                    tgt  = 8'($urandom_range(255));
                end
                default: begin
                    pred = PIX_BG;
                    tgt  = PIX_BG;
                end
            endcase
            // stray target codes
            if ($urandom_range(99) < 5)
                tgt = 8'($urandom_range(255));
            last_img = (i == n_px - 1);
            // group mark without image mark must be ignored
            last_grp = last_img ? grp_end : 1'($urandom_range(1));
            send_word(pred, tgt, last_img, last_grp, 1'b0, '0);
        end
    endtask

    // directed rows: extremes, each pixel class, invalid groups, total saturation
    row_t dir_rows[23] = '{
        '{8'd0,   8'd0,   1'b1, 1'b1, 1'b1, '{17'd32768, 19'd32768,  1'b0, 1'b1}},
        '{8'd255, 8'd255, 1'b1, 1'b1, 1'b1, '{17'd32768, 19'd32768,  1'b0, 1'b1}},
        '{8'd0,   8'd0,   1'b0, 1'b0, 1'b0, '0},
        '{8'd0,   8'd255, 1'b0, 1'b0, 1'b0, '0},
        '{8'd255, 8'd0,   1'b0, 1'b0, 1'b0, '0},
        '{8'd255, 8'd255, 1'b1, 1'b0, 1'b0, '0},
        '{8'd0,   8'd77,  1'b0, 1'b0, 1'b0, '0},
        '{8'd0,   8'd0,   1'b0, 1'b1, 1'b0, '0},
        '{8'd0,   8'd0,   1'b1, 1'b1, 1'b0, '0},
        '{8'd1,   8'd0,   1'b1, 1'b1, 1'b1, '{17'd0,     19'd655,    1'b1, 1'b1}},
        '{8'd0,   8'd0,   1'b1, 1'b0, 1'b0, '0},
        '{8'd254, 8'd255, 1'b0, 1'b0, 1'b0, '0},
        '{8'd0,   8'd0,   1'b1, 1'b0, 1'b1, '{17'd0,     19'd655,    1'b1, 1'b0}},
        '{8'd255, 8'd255, 1'b1, 1'b1, 1'b1, '{17'd0,     19'd655,    1'b1, 1'b1}},
        '{8'd0,   8'd0,   1'b1, 1'b0, 1'b0, '0},
        '{8'd0,   8'd0,   1'b1, 1'b0, 1'b0, '0},
        '{8'd0,   8'd0,   1'b1, 1'b0, 1'b0, '0},
        '{8'd0,   8'd0,   1'b1, 1'b0, 1'b0, '0},
        '{8'd0,   8'd0,   1'b1, 1'b0, 1'b0, '0},
        '{8'd0,   8'd0,   1'b1, 1'b0, 1'b0, '0},
        '{8'd0,   8'd0,   1'b1, 1'b0, 1'b0, '0},
        '{8'd0,   8'd0,   1'b1, 1'b0, 1'b0, '0},
        '{8'd0,   8'd0,   1'b1, 1'b1, 1'b1, '{17'd32768, 19'd262144, 1'b0, 1'b1}}
    };

    // receiver: random backpressure, plus one long hold to fill the job queue
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // score word checker
    always @(posedge aclk) begin
        score_t exp_s;
        if (aresetn && m_tvalid && m_tready) begin
            if (score_q.size() == 0) begin
                $error("score word with nothing expected: %h", m_tdata);
                errors++;
            end else begin
                exp_s = score_q.pop_front();
                if (m_tdata[16:0] !== exp_s.f1) begin
                    $error("image_f1 expected %0d got %0d", exp_s.f1, m_tdata[16:0]);
                    errors++;
                end
                if (m_tdata[35:17] !== exp_s.total) begin
                    $error("group_total expected %0d got %0d", exp_s.total, m_tdata[35:17]);
                    errors++;
                end
                if (m_tuser !== exp_s.invalid) begin
                    $error("group_invalid expected %0d got %0d", exp_s.invalid, m_tuser);
                    errors++;
                end
                if (m_tlast !== exp_s.done) begin
                    $error("group_done expected %0d got %0d", exp_s.done, m_tlast);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        int quiet;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", quiet);
                $display("FAIL binary_mask_f1_score_unit");
                $finish;
            end
        end
    end

    // main sequence
    initial begin
        int rand_sent;
        int n_img;
        int n_px;
        bit bad_grp;
        errors        = 0;
        send_idle_pct = 32;
        recv_idle_pct = 78;
        hold_req      = 1'b0;
        hold_done     = 1'b0;
        tp_cnt        = '0;
        fp_cnt        = '0;
        fn_cnt        = '0;
        sum_acc       = '0;
        bad_seen      = 1'b0;
        n_images      = 0;
        n_groups      = 0;
        n_bad_groups  = 0;
        n_saturated   = 0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        s_tuser       = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed part
        foreach (dir_rows[i])
            send_word(dir_rows[i].pred, dir_rows[i].tgt, dir_rows[i].last_img,
                      dir_rows[i].last_grp, dir_rows[i].typed, dir_rows[i].score);

        // random groups, idling pattern switches by thirds
        rand_sent = 0;
        while (rand_sent < RAND_WORDS) begin
            if (rand_sent < RAND_WORDS / 3) begin
                send_idle_pct = 32;
                recv_idle_pct = 78;
            end else if (rand_sent < 2 * RAND_WORDS / 3) begin
                send_idle_pct = 78;
                recv_idle_pct = 32;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (rand_sent >= 3 * RAND_WORDS / 4)
                hold_req = 1'b1;
            n_img   = ($urandom_range(99) < 70) ? $urandom_range(4, 1) : $urandom_range(6, 5);
            bad_grp = ($urandom_range(99) < 20);
            for (int k = 0; k < n_img; k++) begin
                n_px = ($urandom_range(99) < 80) ? $urandom_range(12, 1)
                                                 : $urandom_range(64, 13);
                send_image(n_px,
                           ($urandom_range(99) < 60) ? $urandom_range(100, 70)
                                                     : $urandom_range(100),
                           bad_grp, k == n_img - 1);
                rand_sent += n_px;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        // drain
        while (score_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d scored images in %0d groups, %0d groups invalid,",
                 n_images, n_groups, n_bad_groups);
        $display("%0d saturated totals, three idling patterns and one long output hold",
                 n_saturated);
        if (errors == 0)
            $display("PASS binary_mask_f1_score_unit");
        else
            $display("FAIL binary_mask_f1_score_unit");
        $finish;
    end

endmodule

/* binary_mask_f1_score_unit.f */
+incdir+src
src/bmf_pkg.sv
src/bmf_front.sv
src/bmf_queue.sv
src/bmf_back.sv
src/binary_mask_f1_score_unit.sv
bench/binary_mask_f1_score_unit_tb.sv
